>>> sv/sli_pkg.sv
// shared types and codes for the sorted list store
`default_nettype none

package sli_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_DUMP   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_ZERO  = 3'd1,
      IDX_INC   = 3'd2,
      IDX_DEC   = 3'd3,
      IDX_COUNT = 3'd4
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_IDX  = 2'd0,
      RD_PREV = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic {
      WS_VALUE = 1'b0,
      WS_RDATA = 1'b1
   } wr_sel_type;

   typedef enum logic [2:0] {
      RSP_NONE      = 3'd0,
      RSP_REJECT    = 3'd1,
      RSP_MISS      = 3'd2,
      RSP_DONE      = 3'd3,
      RSP_ENTRY     = 3'd4,
      RSP_NONE_LEFT = 3'd5
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      idx_op_type   idx_op;
      logic         pos_load;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         cnt_inc;
      logic         cnt_dec;
      rsp_kind_type rsp_kind;
      status_type   rsp_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_end;
      logic at_pos;
      logic at_last;
      logic less;
      logic equal;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> sv/sorted_list_insert_delete.sv
// top level of the sorted list store
//
// keeps up to CAPACITY signed 32-bit values in ascending order in a single-port
// store with registered read data. a command word (req_cmd, req_value) is
// taken at a clock edge where start is high and busy is low.
//   insert: the value goes before the first entry >= it; one result word
//   delete: the first equal entry is removed; one result word
//   dump:   one result word per entry, rsp_last on the final one
// results appear on the rsp_ ports for one cycle each, flagged by rsp_valid;
// the receiver has no way to hold them off and none is needed.
// timing: the store gives one read every other cycle, which sets the pace.
//   rejected insert/delete, empty dump: 1 cycle, result the cycle after
//   insert at index p below n entries: 2p + 2(n - p) + 4 cycles, at the end 2n + 3
//   delete at index p: 2(p + 1) + 2(n - 1 - p) + 2 cycles, miss 2n + 2
//   dump of n entries: 2n + 1 cycles, a result word every other cycle
// the next command may be taken in the cycle its predecessor's last word shows.
// reset empties the list at once; no clearing pass is needed.
`default_nettype none

module sorted_list_insert_delete #(
   parameter int CAPACITY = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_entry_value,
   output logic [5:0]              rsp_position,
   output logic                    rsp_last
);
   import sli_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   sli_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat_i  (stat),
      .busy    (busy),
      .cmd_o   (cmd)
   );

   sli_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd_i           (cmd),
      .req_value       (req_value),
      .stat_o          (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_position    (rsp_position),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

>>> sv/sli_datapath.sv
// store, index registers, compare and result registers of the sorted list
`default_nettype none

module sli_datapath #(
   parameter int CAPACITY = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sli_pkg::ctl_cmd_type cmd_i,
   input  wire logic signed [31:0]  req_value,
   output sli_pkg::dp_stat_type     stat_o,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_entry_value,
   output logic [5:0]               rsp_position,
   output logic                     rsp_last
);
   import sli_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] rdata_ff;
   logic signed [31:0] value_ff;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      rd_idx;
   logic [CW:0]        idx_plus;
   logic signed [31:0] wr_data;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [5:0]         rsp_pos_ff, rsp_pos_in;
   logic               rsp_last_ff, rsp_last_in;

   assign idx_plus = {1'b0, idx_ff} + {{CW{1'b0}}, 1'b1};

   always_comb begin
      stat_o.full    = (cnt_ff == CW'(CAPACITY));
      stat_o.empty   = (cnt_ff == '0);
      stat_o.at_end  = (idx_ff == cnt_ff);
      stat_o.at_pos  = (idx_ff == pos_ff);
      stat_o.at_last = (idx_plus == {1'b0, cnt_ff});
      stat_o.less    = (rdata_ff < value_ff);
      stat_o.equal   = (rdata_ff == value_ff);
   end

   always_comb begin
      unique case (cmd_i.rd_sel)
         RD_PREV: rd_idx = idx_ff - CW'(1);
         RD_NEXT: rd_idx = idx_ff + CW'(1);
         default: rd_idx = idx_ff;
      endcase
   end

   assign wr_data = (cmd_i.wr_sel == WS_RDATA) ? rdata_ff : value_ff;

   always_ff @(posedge clock) begin
      if (cmd_i.wr_en) begin
         mem[idx_ff[AW-1:0]] <= wr_data;
      end
      if (cmd_i.rd_en) begin
         rdata_ff <= mem[rd_idx[AW-1:0]];
      end
   end

   always_comb begin
      unique case (cmd_i.idx_op)
         IDX_ZERO:  idx_in = '0;
         IDX_INC:   idx_in = idx_ff + CW'(1);
         IDX_DEC:   idx_in = idx_ff - CW'(1);
         IDX_COUNT: idx_in = cnt_ff;
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd_i.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd_i.cnt_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd_i.pos_load) begin
         pos_ff <= idx_ff;
      end
      if (cmd_i.load) begin
         value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // result word, shown for one cycle after the command that makes it
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (cmd_i.rsp_kind)
         RSP_REJECT: begin
            rsp_status_in = cmd_i.rsp_status;
            rsp_value_in  = req_value;
            rsp_pos_in    = '0;
            rsp_last_in   = 1'b1;
         end
         RSP_MISS: begin
            rsp_status_in = ST_NOT_FOUND;
            rsp_value_in  = value_ff;
            rsp_pos_in    = '0;
            rsp_last_in   = 1'b1;
         end
         RSP_DONE: begin
            rsp_status_in = ST_OK;
            rsp_value_in  = value_ff;
            rsp_pos_in    = 6'(pos_ff);
            rsp_last_in   = 1'b1;
         end
         RSP_ENTRY: begin
            rsp_status_in = ST_OK;
            rsp_value_in  = rdata_ff;
            rsp_pos_in    = 6'(idx_ff);
            rsp_last_in   = stat_o.at_last;
         end
         RSP_NONE_LEFT: begin
            rsp_status_in = ST_EMPTY;
            rsp_value_in  = '0;
            rsp_pos_in    = '0;
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd_i.rsp_kind != RSP_NONE);
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_last        = rsp_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.cnt_inc || cmd_i.cnt_dec) |=> (cnt_ff != $past(cnt_ff)))
      else $error("entry count did not move on insert or delete");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd_i.cnt_inc |-> !stat_o.full)
      else $error("insert into a full store");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_i.cnt_dec |-> !stat_o.empty)
      else $error("delete from an empty store");

endmodule

`default_nettype wire

>>> sv/sli_ctrl.sv
// controller state machine sequencing scan, shift and dump steps
`default_nettype none

module sli_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          req_cmd,
   input  wire sli_pkg::dp_stat_type stat_i,
   output logic                     busy,
   output sli_pkg::ctl_cmd_type     cmd_o
);
   import sli_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN_RD  = 9'b000000010,
      S_SCAN_CMP = 9'b000000100,
      S_INS_RD   = 9'b000001000,
      S_INS_WR   = 9'b000010000,
      S_DEL_RD   = 9'b000100000,
      S_DEL_WR   = 9'b001000000,
      S_DUMP_RD  = 9'b010000000,
      S_DUMP_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      is_insert_ff, is_insert_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      is_insert_in = is_insert_ff;
      cmd_o        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (stat_i.full) begin
                        cmd_o.rsp_kind   = RSP_REJECT;
                        cmd_o.rsp_status = ST_FULL;
                     end else begin
                        cmd_o.load   = 1'b1;
                        cmd_o.idx_op = IDX_ZERO;
                        is_insert_in = 1'b1;
                        state_in     = S_SCAN_RD;
                     end
                  end
                  CMD_DELETE: begin
                     if (stat_i.empty) begin
                        cmd_o.rsp_kind   = RSP_REJECT;
                        cmd_o.rsp_status = ST_EMPTY;
                     end else begin
                        cmd_o.load   = 1'b1;
                        cmd_o.idx_op = IDX_ZERO;
                        is_insert_in = 1'b0;
                        state_in     = S_SCAN_RD;
                     end
                  end
                  CMD_DUMP: begin
                     if (stat_i.empty) begin
                        cmd_o.rsp_kind = RSP_NONE_LEFT;
                     end else begin
                        cmd_o.idx_op = IDX_ZERO;
                        state_in     = S_DUMP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (stat_i.at_end) begin
               // ran past the last entry
               if (is_insert_ff) begin
                  cmd_o.pos_load = 1'b1;
                  state_in       = S_INS_RD;
               end else begin
                  cmd_o.rsp_kind = RSP_MISS;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd_o.rd_en = 1'b1;
               state_in    = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (is_insert_ff && !stat_i.less) begin
               cmd_o.pos_load = 1'b1;
               cmd_o.idx_op   = IDX_COUNT;
               state_in       = S_INS_RD;
            end else if (!is_insert_ff && stat_i.equal) begin
               cmd_o.pos_load = 1'b1;
               state_in       = S_DEL_RD;
            end else begin
               cmd_o.idx_op = IDX_INC;
               state_in     = S_SCAN_RD;
            end
         end
         S_INS_RD: begin
            if (stat_i.at_pos) begin
               cmd_o.wr_en    = 1'b1;
               cmd_o.wr_sel   = WS_VALUE;
               cmd_o.cnt_inc  = 1'b1;
               cmd_o.rsp_kind = RSP_DONE;
               state_in       = S_IDLE;
            end else begin
               cmd_o.rd_en  = 1'b1;
               cmd_o.rd_sel = RD_PREV;
               state_in     = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WS_RDATA;
            cmd_o.idx_op = IDX_DEC;
            state_in     = S_INS_RD;
         end
         S_DEL_RD: begin
            if (stat_i.at_last) begin
               cmd_o.cnt_dec  = 1'b1;
               cmd_o.rsp_kind = RSP_DONE;
               state_in       = S_IDLE;
            end else begin
               cmd_o.rd_en  = 1'b1;
               cmd_o.rd_sel = RD_NEXT;
               state_in     = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WS_RDATA;
            cmd_o.idx_op = IDX_INC;
            state_in     = S_DEL_RD;
         end
         S_DUMP_RD: begin
            cmd_o.rd_en = 1'b1;
            state_in    = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            cmd_o.rsp_kind = RSP_ENTRY;
            if (stat_i.at_last) begin
               state_in = S_IDLE;
            end else begin
               cmd_o.idx_op = IDX_INC;
               state_in     = S_DUMP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         is_insert_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_insert_ff <= is_insert_in;
      end
   end

   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CMP) |-> ($past(state_ff) == S_SCAN_RD))
      else $error("compare step without a preceding read");

   a_inc_done: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.cnt_inc || cmd_o.cnt_dec) |-> (cmd_o.rsp_kind == RSP_DONE))
      else $error("count change without a result word");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.rsp_kind == RSP_DONE) |=> (state_ff == S_IDLE))
      else $error("controller did not return to idle after completion");

endmodule

`default_nettype wire
